/* hw/rtl/nearest_seed_voxel_labeling_unit_defines.svh */
// Assertion macros for the nearest-seed voxel labeling unit.
`ifndef NEAREST_SEED_VOXEL_LABELING_UNIT_DEFINES_SVH
`define NEAREST_SEED_VOXEL_LABELING_UNIT_DEFINES_SVH

// Check a property outside reset.
`define NSVL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define NSVL_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hw/rtl/nsvl_pkg.sv */
// Package with constants, codes and types of the nearest-seed voxel labeling unit.
`default_nettype none

package nsvl_pkg;

    localparam int MAX_SEEDS      = 64;
    localparam int COORD_BITS     = 10;
    localparam int LABEL_BITS     = 16;
    localparam int VALUE_BITS     = 16;
    localparam int SLOT_BITS      = 6;
    localparam int METRIC_BITS    = 2;
    localparam int CNT_BITS       = 7;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam int COMP_BITS  = 2 * COORD_BITS;
    localparam int DIST_BITS  = 2 * COORD_BITS + 2;
    localparam int CHAIN_LEN  = MAX_SEEDS + 2;
    localparam int IDX_BITS   = $clog2(CHAIN_LEN);

    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    localparam logic [METRIC_BITS-1:0] METRIC_EUCLID    = 2'd0;
    localparam logic [METRIC_BITS-1:0] METRIC_MANHATTAN = 2'd1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_METRIC = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COUNT  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_EMPTY  = 2'd2;

    typedef struct packed {
        logic [METRIC_BITS-1:0] metric;
        logic [CNT_BITS-1:0]    count;
    } t_cfg;

    typedef struct packed {
        logic                   command;
        logic [SLOT_BITS-1:0]   seed_slot;
        logic [COORD_BITS-1:0]  coord_x;
        logic [COORD_BITS-1:0]  coord_y;
        logic [COORD_BITS-1:0]  coord_z;
        logic [VALUE_BITS-1:0]  value;
        logic                   comp_vld;
        logic [COMP_BITS-1:0]   comp_x;
        logic [COMP_BITS-1:0]   comp_y;
        logic [COMP_BITS-1:0]   comp_z;
        logic [LABEL_BITS-1:0]  comp_label;
        logic                   dist_vld;
        logic [DIST_BITS-1:0]   span;
        logic [LABEL_BITS-1:0]  dist_label;
        logic                   found;
        logic [DIST_BITS-1:0]   best;
        logic [LABEL_BITS-1:0]  best_label;
    } t_item;

endpackage

`default_nettype wire

/* hw/rtl/nsvl_in_if.sv */
// Input channel: load and classify words.
`default_nettype none

interface nsvl_in_if;
    logic                              valid;
    logic                              ready;
    logic                              command;
    logic [nsvl_pkg::SLOT_BITS-1:0]    seed_slot;
    logic [nsvl_pkg::COORD_BITS-1:0]   coord_x;
    logic [nsvl_pkg::COORD_BITS-1:0]   coord_y;
    logic [nsvl_pkg::COORD_BITS-1:0]   coord_z;
    logic [nsvl_pkg::VALUE_BITS-1:0]   label_or_value;

    modport source (
        output valid, command, seed_slot, coord_x, coord_y, coord_z, label_or_value,
        input  ready
    );
    modport sink (
        input  valid, command, seed_slot, coord_x, coord_y, coord_z, label_or_value,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/nsvl_out_if.sv */
// Output channel: labeled voxel values.
`default_nettype none

interface nsvl_out_if;
    logic                              valid;
    logic                              ready;
    logic [nsvl_pkg::VALUE_BITS-1:0]   new_value;

    modport source (output valid, new_value, input ready);
    modport sink (input valid, new_value, output ready);
endinterface

`default_nettype wire

/* hw/rtl/nearest_seed_voxel_labeling_unit.sv */
// A classify word passes the input register, the seed cells and the output register.
// Throughput: one word per cycle; the seed cell chain takes a new word every cycle.
// The whole chain stalls together while the output register holds an untaken word.
// Reset clears the pipeline valid bits and the configuration registers.
// Seed slots hold no defined value until a load word writes them.
`default_nettype none

module nearest_seed_voxel_labeling_unit (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    nsvl_in_if.sink                                 i_in,
    nsvl_out_if.source                              o_out,
    input  logic                                    i_cfg_we,
    input  logic [nsvl_pkg::CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  logic [nsvl_pkg::CFG_DATA_BITS-1:0]      i_cfg_wdata
);

    logic                                   advance;
    logic [nsvl_pkg::METRIC_BITS-1:0]       r_metric;
    logic [nsvl_pkg::CNT_BITS-1:0]          r_count;
    logic [nsvl_pkg::VALUE_BITS-1:0]        r_empty;
    nsvl_pkg::t_cfg                         cfg;
    logic                                   r_in_valid;
    nsvl_pkg::t_item                        r_in_item;
    nsvl_pkg::t_item                        n_in_item;
    logic                                   stg_valid [nsvl_pkg::CHAIN_LEN+1];
    nsvl_pkg::t_item                        stg_item  [nsvl_pkg::CHAIN_LEN+1];
    nsvl_pkg::t_item                        last;
    logic                                   r_out_valid;
    logic [nsvl_pkg::VALUE_BITS-1:0]        r_out_value;
    logic [nsvl_pkg::VALUE_BITS-1:0]        n_out_value;

    assign advance    = i_rst_n && (!r_out_valid || o_out.ready);
    assign i_in.ready = advance;

    assign cfg.metric = r_metric;
    assign cfg.count  = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metric <= '0;
            r_count  <= '0;
            r_empty  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                nsvl_pkg::CFG_METRIC: r_metric <= i_cfg_wdata[nsvl_pkg::METRIC_BITS-1:0];
                nsvl_pkg::CFG_COUNT:  r_count  <= i_cfg_wdata[nsvl_pkg::CNT_BITS-1:0];
                nsvl_pkg::CFG_EMPTY:  r_empty  <= i_cfg_wdata[nsvl_pkg::VALUE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_in_item           = '0;
        n_in_item.command   = i_in.command;
        n_in_item.seed_slot = i_in.seed_slot;
        n_in_item.coord_x   = i_in.coord_x;
        n_in_item.coord_y   = i_in.coord_y;
        n_in_item.coord_z   = i_in.coord_z;
        n_in_item.value     = i_in.label_or_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (advance) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_in_item <= n_in_item;
        end
    end

    assign stg_valid[0] = r_in_valid;
    assign stg_item[0]  = r_in_item;

    for (genvar c = 0; c < nsvl_pkg::CHAIN_LEN; c++) begin : g_cell
        nsvl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (advance),
            .i_index (nsvl_pkg::IDX_BITS'(c)),
            .i_cfg   (cfg),
            .i_valid (stg_valid[c]),
            .i_item  (stg_item[c]),
            .o_valid (stg_valid[c+1]),
            .o_item  (stg_item[c+1])
        );
    end

    assign last = stg_item[nsvl_pkg::CHAIN_LEN];

    assign n_out_value = ((last.value == r_empty) || !last.found)
                         ? last.value
                         : nsvl_pkg::VALUE_BITS'(last.best_label);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= stg_valid[nsvl_pkg::CHAIN_LEN]
                           && (last.command == nsvl_pkg::CMD_CLASSIFY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_value <= n_out_value;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.new_value = r_out_value;

endmodule

`default_nettype wire

/* hw/rtl/nsvl_cell.sv */
// Seed cell: holds one seed, computes its distance terms and merges the best candidate.
`default_nettype none

module nsvl_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_adv,
    input  logic [nsvl_pkg::IDX_BITS-1:0]   i_index,
    input  nsvl_pkg::t_cfg                  i_cfg,
    input  logic                            i_valid,
    input  nsvl_pkg::t_item                 i_item,
    output logic                            o_valid,
    output nsvl_pkg::t_item                 o_item
);

    logic                               has_seed;
    logic                               part;
    logic                               load_hit;
    logic                               take;
    logic [nsvl_pkg::COORD_BITS-1:0]    r_seed_x;
    logic [nsvl_pkg::COORD_BITS-1:0]    r_seed_y;
    logic [nsvl_pkg::COORD_BITS-1:0]    r_seed_z;
    logic [nsvl_pkg::LABEL_BITS-1:0]    r_seed_label;
    logic [nsvl_pkg::COORD_BITS-1:0]    dx;
    logic [nsvl_pkg::COORD_BITS-1:0]    dy;
    logic [nsvl_pkg::COORD_BITS-1:0]    dz;
    logic [nsvl_pkg::DIST_BITS-1:0]     ext_x;
    logic [nsvl_pkg::DIST_BITS-1:0]     ext_y;
    logic [nsvl_pkg::DIST_BITS-1:0]     ext_z;
    logic [nsvl_pkg::DIST_BITS-1:0]     max_xy;
    logic [nsvl_pkg::DIST_BITS-1:0]     seed_span;
    logic                               r_valid;
    nsvl_pkg::t_item                    r_item;
    nsvl_pkg::t_item                    n_item;

    assign has_seed = int'(i_index) < nsvl_pkg::MAX_SEEDS;
    assign part     = has_seed && (int'(i_index) < int'(i_cfg.count));
    assign load_hit = i_adv && i_valid && (i_item.command == nsvl_pkg::CMD_LOAD)
                      && has_seed && (int'(i_item.seed_slot) == int'(i_index));

    assign dx = (r_seed_x >= i_item.coord_x) ? r_seed_x - i_item.coord_x
                                             : i_item.coord_x - r_seed_x;
    assign dy = (r_seed_y >= i_item.coord_y) ? r_seed_y - i_item.coord_y
                                             : i_item.coord_y - r_seed_y;
    assign dz = (r_seed_z >= i_item.coord_z) ? r_seed_z - i_item.coord_z
                                             : i_item.coord_z - r_seed_z;

    assign ext_x  = nsvl_pkg::DIST_BITS'(i_item.comp_x);
    assign ext_y  = nsvl_pkg::DIST_BITS'(i_item.comp_y);
    assign ext_z  = nsvl_pkg::DIST_BITS'(i_item.comp_z);
    assign max_xy = (ext_y > ext_x) ? ext_y : ext_x;

    always_comb begin
        unique case (i_cfg.metric)
            nsvl_pkg::METRIC_EUCLID,
            nsvl_pkg::METRIC_MANHATTAN: begin
                seed_span = ext_x + ext_y + ext_z;
            end
            default: begin
                seed_span = (ext_z > max_xy) ? ext_z : max_xy;
            end
        endcase
    end

    assign take = i_item.dist_vld && (!i_item.found || (i_item.span < i_item.best));

    always_comb begin
        n_item = i_item;
        // terms of this cell's seed
        n_item.comp_vld   = part;
        n_item.comp_label = r_seed_label;
        if (i_cfg.metric == nsvl_pkg::METRIC_EUCLID) begin
            n_item.comp_x = nsvl_pkg::COMP_BITS'(dx) * nsvl_pkg::COMP_BITS'(dx);
            n_item.comp_y = nsvl_pkg::COMP_BITS'(dy) * nsvl_pkg::COMP_BITS'(dy);
            n_item.comp_z = nsvl_pkg::COMP_BITS'(dz) * nsvl_pkg::COMP_BITS'(dz);
        end else begin
            n_item.comp_x = nsvl_pkg::COMP_BITS'(dx);
            n_item.comp_y = nsvl_pkg::COMP_BITS'(dy);
            n_item.comp_z = nsvl_pkg::COMP_BITS'(dz);
        end
        // distance of the previous seed
        n_item.dist_vld   = i_item.comp_vld;
        n_item.span       = seed_span;
        n_item.dist_label = i_item.comp_label;
        // keep the lowest slot on a tie
        if (take) begin
            n_item.found      = 1'b1;
            n_item.best       = i_item.span;
            n_item.best_label = i_item.dist_label;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_hit) begin
            r_seed_x     <= i_item.coord_x;
            r_seed_y     <= i_item.coord_y;
            r_seed_z     <= i_item.coord_z;
            r_seed_label <= nsvl_pkg::LABEL_BITS'(i_item.value);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

/* hw/rtl/nsvl_checker.sv */
// Port checker for the nearest-seed voxel labeling unit, with its bind.
`default_nettype none
`include "nearest_seed_voxel_labeling_unit_defines.svh"

module nsvl_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_ready,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [nsvl_pkg::VALUE_BITS-1:0] i_out_new_value
);

    `NSVL_ASSERT_RST(a_rst_clears_out, !i_rst_n |=> !i_out_valid, "output valid after reset")
    `NSVL_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_new_value), "stalled result word changed")
    `NSVL_ASSERT(a_stall_blocks_in, i_out_valid && !i_out_ready |-> !i_in_ready, "input taken while output stalled")
    `NSVL_ASSERT(a_out_needs_adv, $rose(i_out_valid) |-> $past(i_in_ready), "result word appeared without pipeline advance")

endmodule

bind nearest_seed_voxel_labeling_unit nsvl_checker u_nsvl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_new_value (o_out.new_value)
);

`default_nettype wire

/* dv/tb_nearest_seed_voxel_labeling_unit.sv */
// Testbench: nearest-seed voxel labeling unit, directed steps then random phases vs a predictor.
module tb_nearest_seed_voxel_labeling_unit;
    import nsvl_pkg::*;

    localparam int DRAIN_CYCLES = MAX_SEEDS + 8;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_WORDS  = 50;
    localparam int RUN_LIMIT    = 5_000_000;
    localparam int NUM_STEPS    = 32;

    localparam logic [METRIC_BITS-1:0] METRIC_CHEBYSHEV = 2'd2;
    localparam logic [METRIC_BITS-1:0] METRIC_SPARE     = 2'd3;
    localparam logic [COORD_BITS-1:0]  HI               = 10'd1023;

    typedef enum logic {DO_WORD, DO_REG} t_step_kind;

    typedef struct packed {
        t_step_kind                kind;
        logic                      cmd;
        logic [SLOT_BITS-1:0]      slot;
        logic [COORD_BITS-1:0]     x;
        logic [COORD_BITS-1:0]     y;
        logic [COORD_BITS-1:0]     z;
        logic [CFG_DATA_BITS-1:0]  data;
        logic [CFG_INDEX_BITS-1:0] reg_index;
        logic                      typed;
        logic [VALUE_BITS-1:0]     want;
    } t_step_row;

    localparam t_step_row DIRECTED_STEPS [0:NUM_STEPS-1] = '{
        '{DO_WORD, CMD_CLASSIFY, 6'd0, 10'd0, 10'd0, 10'd0, 16'h1234, CFG_METRIC, 1'b1, 16'h1234},
        '{DO_WORD, CMD_CLASSIFY, 6'd63, HI, HI, HI, 16'hFFFF, CFG_METRIC, 1'b1, 16'hFFFF},
        '{DO_WORD, CMD_CLASSIFY, 6'd0, 10'd5, 10'd6, 10'd7, 16'h0000, CFG_METRIC, 1'b1, 16'h0000},
        '{DO_WORD, CMD_LOAD, 6'd0, 10'd0, 10'd0, 10'd0, 16'h0001, CFG_METRIC, 1'b0, 16'h0000},
        '{DO_WORD, CMD_LOAD, 6'd1, HI, HI, HI, 16'hFFFF, CFG_METRIC, 1'b0, 16'h0000},
        '{DO_WORD, CMD_LOAD, 6'd2, 10'd0, HI, 10'd0, 16'h00A5, CFG_METRIC, 1'b0, 16'h0000},
        '{DO_WORD, CMD_LOAD, 6'd3, HI, 10'd0, HI, 16'h5A5A, CFG_METRIC, 1'b0, 16'h0000},
        '{DO_WORD, CMD_LOAD, 6'd4, 10'd0, 10'd0, 10'd0, 16'h8000, CFG_METRIC, 1'b0, 16'h0000},
        '{DO_WORD, CMD_LOAD, 6'd63, 10'd512, 10'd512, 10'd512, 16'hC3C3, CFG_METRIC, 1'b0,
          16'h0000},
        '{DO_REG, CMD_LOAD, 6'd0, 10'd0, 10'd0, 10'd0, 16'd5, CFG_COUNT, 1'b0, 16'h0000},
        '{DO_WORD, CMD_CLASSIFY, 6'd0, 10'd0, 10'd0, 10'd0, 16'h7777, CFG_METRIC, 1'b1, 16'h0001},
        '{DO_WORD, CMD_CLASSIFY, 6'd0, HI, HI, HI, 16'h0100, CFG_METRIC, 1'b1, 16'hFFFF},
        '{DO_WORD, CMD_CLASSIFY, 6'd0, 10'd0, 10'd0, 10'd0, 16'h0000, CFG_METRIC, 1'b1, 16'h0000},
        '{DO_WORD, CMD_CLASSIFY, 6'd0, 10'd600, 10'd600, 10'd600, 16'h0001, CFG_METRIC, 1'b0,
          16'h0000},
        '{DO_WORD, CMD_CLASSIFY, 6'd0, 10'd0, HI, HI, 16'h0002, CFG_METRIC, 1'b0, 16'h0000},
        '{DO_REG, CMD_LOAD, 6'd0, 10'd0, 10'd0, 10'd0, 16'(METRIC_MANHATTAN), CFG_METRIC, 1'b0,
          16'h0000},
        '{DO_WORD, CMD_CLASSIFY, 6'd0, 10'd0, HI, HI, 16'h0003, CFG_METRIC, 1'b0, 16'h0000},
        '{DO_WORD, CMD_CLASSIFY, 6'd0, 10'd300, 10'd900, 10'd100, 16'h0004, CFG_METRIC, 1'b0,
          16'h0000},
        '{DO_REG, CMD_LOAD, 6'd0, 10'd0, 10'd0, 10'd0, 16'(METRIC_CHEBYSHEV), CFG_METRIC, 1'b0,
          16'h0000},
        '{DO_WORD, CMD_CLASSIFY, 6'd0, 10'd300, 10'd900, 10'd100, 16'h0005, CFG_METRIC, 1'b0,
          16'h0000},
        '{DO_WORD, CMD_CLASSIFY, 6'd0, HI, 10'd0, 10'd0, 16'h0006, CFG_METRIC, 1'b0, 16'h0000},
        '{DO_REG, CMD_LOAD, 6'd0, 10'd0, 10'd0, 10'd0, 16'(METRIC_SPARE), CFG_METRIC, 1'b0,
          16'h0000},
        '{DO_WORD, CMD_CLASSIFY, 6'd0, 10'd300, 10'd900, 10'd100, 16'h0007, CFG_METRIC, 1'b0,
          16'h0000},
        '{DO_REG, CMD_LOAD, 6'd0, 10'd0, 10'd0, 10'd0, 16'hFFFF, CFG_EMPTY, 1'b0, 16'h0000},
        '{DO_WORD, CMD_CLASSIFY, 6'd0, 10'd1, 10'd2, 10'd3, 16'hFFFF, CFG_METRIC, 1'b1, 16'hFFFF},
        '{DO_WORD, CMD_CLASSIFY, 6'd0, 10'd1, 10'd2, 10'd3, 16'h0000, CFG_METRIC, 1'b0, 16'h0000},
        '{DO_REG, CMD_LOAD, 6'd0, 10'd0, 10'd0, 10'd0, 16'd0, CFG_COUNT, 1'b0, 16'h0000},
        '{DO_WORD, CMD_CLASSIFY, 6'd0, 10'd9, 10'd9, 10'd9, 16'hABCD, CFG_METRIC, 1'b1, 16'hABCD},
        '{DO_REG, CMD_LOAD, 6'd0, 10'd0, 10'd0, 10'd0, 16'd1, CFG_COUNT, 1'b0, 16'h0000},
        '{DO_REG, CMD_LOAD, 6'd0, 10'd0, 10'd0, 10'd0, 16'(METRIC_EUCLID), CFG_METRIC, 1'b0,
          16'h0000},
        '{DO_REG, CMD_LOAD, 6'd0, 10'd0, 10'd0, 10'd0, 16'h0000, CFG_EMPTY, 1'b0, 16'h0000},
        '{DO_WORD, CMD_CLASSIFY, 6'd0, HI, HI, HI, 16'h4444, CFG_METRIC, 1'b1, 16'h0001}
    };

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [CFG_DATA_BITS-1:0]  i_cfg_wdata;

    nsvl_in_if  word_in ();
    nsvl_out_if word_out ();

    nearest_seed_voxel_labeling_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (word_in),
        .o_out       (word_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    logic [COORD_BITS-1:0]  seed_x     [MAX_SEEDS];
    logic [COORD_BITS-1:0]  seed_y     [MAX_SEEDS];
    logic [COORD_BITS-1:0]  seed_z     [MAX_SEEDS];
    logic [LABEL_BITS-1:0]  seed_label [MAX_SEEDS];
    logic [METRIC_BITS-1:0] metric_sel   = METRIC_EUCLID;
    logic [CNT_BITS-1:0]    search_count = '0;
    logic [VALUE_BITS-1:0]  empty_value  = '0;

    logic [VALUE_BITS-1:0]  pending_values [$];
    logic [VALUE_BITS-1:0]  oldest_value;

    int src_gap_max  = 18;
    int sink_gap_max = 18;
    int mismatches   = 0;
    int values_seen  = 0;
    int loads_sent   = 0;
    int voxels_sent  = 0;
    int reg_writes   = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #RUN_LIMIT;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int unsigned seed_gap(input int slot, input logic [COORD_BITS-1:0] vx,
                                             input logic [COORD_BITS-1:0] vy,
                                             input logic [COORD_BITS-1:0] vz);
        int unsigned dx, dy, dz, m;
        dx = (seed_x[slot] >= vx) ? seed_x[slot] - vx : vx - seed_x[slot];
        dy = (seed_y[slot] >= vy) ? seed_y[slot] - vy : vy - seed_y[slot];
        dz = (seed_z[slot] >= vz) ? seed_z[slot] - vz : vz - seed_z[slot];
        case (metric_sel)
            METRIC_EUCLID:    return dx * dx + dy * dy + dz * dz;
            METRIC_MANHATTAN: return dx + dy + dz;
            default: begin
                m = dx;
                if (dy > m) m = dy;
                if (dz > m) m = dz;
                return m;
            end
        endcase
    endfunction

    function automatic logic [VALUE_BITS-1:0] nearest_label(input logic [COORD_BITS-1:0] vx,
                                                            input logic [COORD_BITS-1:0] vy,
                                                            input logic [COORD_BITS-1:0] vz,
                                                            input logic [VALUE_BITS-1:0] cur);
        int unsigned n, d, best;
        bit found;
        logic [VALUE_BITS-1:0] lbl;
        lbl   = cur;
        found = 1'b0;
        best  = 0;
        n     = (search_count > MAX_SEEDS) ? MAX_SEEDS : search_count;
        if (cur != empty_value) begin
            for (int i = 0; i < n; i++) begin
                d = seed_gap(i, vx, vy, vz);
                if (!found || d < best) begin
                    found = 1'b1;
                    best  = d;
                    lbl   = seed_label[i][VALUE_BITS-1:0];
                end
            end
        end
        return lbl;
    endfunction

    function automatic logic [COORD_BITS-1:0] rand_coord(input int mode);
        case (mode)
            0:       return COORD_BITS'($urandom_range(0, 7));
            1:       return $urandom_range(0, 1) ? HI : '0;
            2:       return COORD_BITS'($urandom_range(1016, 1023));
            default: return COORD_BITS'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic int pick_gap();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 4;
            default: return 18;
        endcase
    endfunction

    task automatic send_word(input logic cmd, input logic [SLOT_BITS-1:0] slot,
                             input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                             input logic [COORD_BITS-1:0] z, input logic [VALUE_BITS-1:0] v,
                             input logic typed, input logic [VALUE_BITS-1:0] want);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        repeat (gap) @(negedge i_clk);
        word_in.command        = cmd;
        word_in.seed_slot      = slot;
        word_in.coord_x        = x;
        word_in.coord_y        = y;
        word_in.coord_z        = z;
        word_in.label_or_value = v;
        word_in.valid          = 1'b1;
        do @(posedge i_clk); while (word_in.ready !== 1'b1);
        if (cmd == CMD_LOAD) begin
            seed_x[slot]     = x;
            seed_y[slot]     = y;
            seed_z[slot]     = z;
            seed_label[slot] = v;
            loads_sent++;
        end else begin
            pending_values.insert(pending_values.size(),
                                  typed ? want : nearest_label(x, y, z, v));
            voxels_sent++;
        end
        @(negedge i_clk);
        word_in.valid = 1'b0;
    endtask

    // hold until every value word is back and the seed chain is empty
    task automatic drain_pipeline();
        while (pending_values.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_METRIC: metric_sel   = data[METRIC_BITS-1:0];
            CFG_COUNT:  search_count = data[CNT_BITS-1:0];
            CFG_EMPTY:  empty_value  = data[VALUE_BITS-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic random_word();
        int mode, live;
        logic [SLOT_BITS-1:0]  slot;
        logic [VALUE_BITS-1:0] v;
        mode = $urandom_range(0, 3);
        live = (search_count > MAX_SEEDS) ? MAX_SEEDS : search_count;
        slot = SLOT_BITS'($urandom_range(0, MAX_SEEDS - 1));
        if ($urandom_range(0, 9) < 3) begin
            if (live != 0 && $urandom_range(0, 1)) slot = SLOT_BITS'($urandom_range(0, live - 1));
            send_word(CMD_LOAD, slot, rand_coord(mode), rand_coord(mode), rand_coord(mode),
                      VALUE_BITS'($urandom_range(0, 65535)), 1'b0, '0);
        end else begin
            v = ($urandom_range(0, 4) == 0) ? empty_value : VALUE_BITS'($urandom_range(0, 65535));
            send_word(CMD_CLASSIFY, slot, rand_coord(mode), rand_coord(mode), rand_coord(mode),
                      v, 1'b0, '0);
        end
    endtask

    initial begin : value_sink
        int stall;
        word_out.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = $urandom_range(0, sink_gap_max);
            if (stall != 0) begin
                word_out.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            word_out.ready = 1'b1;
            do @(posedge i_clk); while (word_out.valid !== 1'b1);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && word_out.valid === 1'b1 && word_out.ready === 1'b1) begin
            values_seen++;
            if (pending_values.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: value word %h arrived with nothing pending",
                             word_out.new_value);
            end else begin
                oldest_value = pending_values[0];
                pending_values.delete(0);
                if (word_out.new_value !== oldest_value) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: new_value expected %h got %h",
                                 oldest_value, word_out.new_value);
                end
            end
        end
    end

    initial begin : stimulus
        int p, k, s;
        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_index            = CFG_METRIC;
        i_cfg_wdata            = '0;
        word_in.valid          = 1'b0;
        word_in.command        = CMD_LOAD;
        word_in.seed_slot      = '0;
        word_in.coord_x        = '0;
        word_in.coord_y        = '0;
        word_in.coord_z        = '0;
        word_in.label_or_value = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (s = 0; s < NUM_STEPS; s++) begin
            if (DIRECTED_STEPS[s].kind == DO_REG) begin
                drain_pipeline();
                write_reg(DIRECTED_STEPS[s].reg_index, DIRECTED_STEPS[s].data);
            end else begin
                send_word(DIRECTED_STEPS[s].cmd, DIRECTED_STEPS[s].slot, DIRECTED_STEPS[s].x,
                          DIRECTED_STEPS[s].y, DIRECTED_STEPS[s].z, DIRECTED_STEPS[s].data,
                          DIRECTED_STEPS[s].typed, DIRECTED_STEPS[s].want);
            end
        end

        // fill every slot so any seed count is legal from here on
        for (s = 0; s < MAX_SEEDS; s++) begin
            k = $urandom_range(0, 3);
            send_word(CMD_LOAD, SLOT_BITS'(s), rand_coord(k), rand_coord(k), rand_coord(k),
                      VALUE_BITS'($urandom_range(0, 65535)), 1'b0, '0);
            if (s % 4 == 3) random_word();
        end

        for (p = 0; p < RAND_PHASES; p++) begin
            drain_pipeline();
            case (p)
                0: begin
                    write_reg(CFG_METRIC, 16'(METRIC_EUCLID));
                    write_reg(CFG_COUNT, 16'(MAX_SEEDS));
                    write_reg(CFG_EMPTY, 16'h0000);
                    src_gap_max  = 0;
                    sink_gap_max = 0;
                end
                1: begin
                    write_reg(CFG_METRIC, 16'hFFFF);
                    write_reg(CFG_COUNT, 16'hFFFF);
                    write_reg(CFG_EMPTY, 16'hFFFF);
                    src_gap_max  = 18;
                    sink_gap_max = 18;
                end
                2: begin
                    write_reg(CFG_METRIC, 16'(METRIC_CHEBYSHEV));
                    write_reg(CFG_COUNT, 16'd1);
                    write_reg(CFG_EMPTY, 16'(VALUE_BITS'($urandom_range(0, 65535))));
                    src_gap_max  = 0;
                    sink_gap_max = 18;
                end
                3: begin
                    write_reg(CFG_METRIC, 16'(METRIC_MANHATTAN));
                    write_reg(CFG_COUNT, 16'(MAX_SEEDS + 1));
                    write_reg(CFG_EMPTY, 16'h0000);
                    src_gap_max  = 18;
                    sink_gap_max = 0;
                end
                default: begin
                    write_reg(CFG_METRIC, 16'($urandom_range(0, 3)));
                    write_reg(CFG_COUNT, 16'($urandom_range(0, 127)));
                    write_reg(CFG_EMPTY, 16'($urandom_range(0, 65535)));
                    src_gap_max  = pick_gap();
                    sink_gap_max = pick_gap();
                end
            endcase
            for (k = 0; k < PHASE_WORDS; k++) random_word();
        end

        while (pending_values.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d seed loads and %0d voxel lookups across %0d register writes",
                 loads_sent, voxels_sent, reg_writes);
        $display("compared %0d labeled values, %0d mismatches", values_seen, mismatches);
        if (mismatches == 0 && pending_values.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/nsvl_pkg.sv
hw/rtl/nsvl_in_if.sv
hw/rtl/nsvl_out_if.sv
hw/rtl/nsvl_cell.sv
hw/rtl/nearest_seed_voxel_labeling_unit.sv
hw/rtl/nsvl_checker.sv
dv/tb_nearest_seed_voxel_labeling_unit.sv
